// ===== hdl/spsc_pkg.sv =====
// ----------------------------------------------------------------------------
// spsc_pkg
// Shared widths, command and status types, and elaboration-time helpers for
// the segmented prime sieve counter.
// ----------------------------------------------------------------------------
package spsc_pkg;

    localparam int LIM_W      = 21;
    localparam int POS_W      = 22;
    localparam int NMAX_W     = 31;
    localparam int LIMIT_MAX  = (2 ** LIM_W) - 1;
    localparam int MAX_N_DEF  = 1048576;
    localparam int SEG_SIZE_DEF = 4096;

    typedef struct packed {
        logic load_n;
        logic root_step;
        logic idx_clr;
        logic base_init_wr;
        logic p_init;
        logic p_inc;
        logic m_sq;
        logic base_mark_wr;
        logic seg_clr;
        logic seg_top;
        logic seg_fill_wr;
        logic m_load;
        logic seg_mark_wr;
        logic next_wr;
        logic cnt_start;
        logic cnt_rd;
        logic seg_adv;
        logic out_ld;
    } t_cmd;

    typedef struct packed {
        logic root_more;
        logic idx_at_root;
        logic p_le_root;
        logic base_flag;
        logic m_le_root;
        logic fill_last;
        logic m_le_end;
        logic seg_le_n;
        logic k_le_end;
    } t_sts;

    function automatic int isqrt(input int v);
        int r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) begin
            r = r + 1;
        end
        return r;
    endfunction

    function automatic int base_depth(input int max_n);
        return isqrt((max_n < LIMIT_MAX) ? max_n : LIMIT_MAX) + 1;
    endfunction

endpackage

// ===== hdl/spsc_ram.sv =====
// ----------------------------------------------------------------------------
// spsc_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module spsc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/spsc_datapath.sv =====
// ----------------------------------------------------------------------------
// spsc_datapath
// Counters, flag memories and the running total of the sieve. Acts on the
// commands of the controller and reports comparisons back as status.
// ----------------------------------------------------------------------------
module spsc_datapath #(
    parameter int MAX_N    = spsc_pkg::MAX_N_DEF,
    parameter int SEG_SIZE = spsc_pkg::SEG_SIZE_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  spsc_pkg::t_cmd            i_cmd,
    input  logic [spsc_pkg::LIM_W-1:0] i_limit,
    output spsc_pkg::t_sts            o_sts,
    output logic [spsc_pkg::LIM_W-1:0] o_num_primes
);
    import spsc_pkg::*;

    localparam int BaseDepth = base_depth(MAX_N);
    localparam int BaseAw    = $clog2(BaseDepth);
    localparam int RootW     = $clog2(BaseDepth + 1);
    localparam int SegAw     = $clog2(SEG_SIZE);
    localparam logic [NMAX_W-1:0] MaxNV    = NMAX_W'(MAX_N);
    localparam logic [POS_W-1:0]  SegStep  = POS_W'(SEG_SIZE);
    localparam logic [POS_W-1:0]  SegLast  = POS_W'(SEG_SIZE - 1);

    logic [LIM_W-1:0] r_n;
    logic [RootW-1:0] r_root;
    logic [RootW-1:0] r_p;
    logic [POS_W-1:0] r_sq;
    logic [POS_W-1:0] r_psq;
    logic [POS_W-1:0] r_idx;
    logic [POS_W-1:0] r_m;
    logic [POS_W-1:0] r_seg;
    logic [POS_W-1:0] r_end;
    logic [POS_W-1:0] r_k;
    logic [LIM_W-1:0] r_total;
    logic [LIM_W-1:0] r_out;
    logic             r_cnt_pend;

    logic [LIM_W-1:0] n_n;
    logic [POS_W-1:0] n_end;
    logic [POS_W-1:0] m_off;
    logic [POS_W-1:0] k_off;
    logic             base_rdata;
    logic             seg_rdata;
    logic [POS_W-1:0] next_rdata;

    always_comb begin
        n_n = (NMAX_W'(i_limit) > MaxNV) ? MaxNV[LIM_W-1:0] : i_limit;
        n_end = r_seg + SegLast;
        if (n_end > POS_W'(r_n)) begin
            n_end = POS_W'(r_n);
        end
    end

    assign m_off = r_m - r_seg;
    assign k_off = r_k - r_seg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total    <= '0;
            r_cnt_pend <= 1'b0;
        end else begin
            if (i_cmd.load_n) begin
                r_total <= '0;
            end else if (r_cnt_pend && seg_rdata) begin
                r_total <= r_total + LIM_W'(1);
            end
            r_cnt_pend <= i_cmd.cnt_rd && (r_k >= POS_W'(2));
        end
    end

    always_ff @(posedge i_clk) begin
        r_psq <= POS_W'(r_p) * POS_W'(r_p);
        if (i_cmd.load_n) begin
            r_n    <= n_n;
            r_root <= '0;
            r_sq   <= POS_W'(1);
        end
        if (i_cmd.root_step) begin
            r_root <= r_root + RootW'(1);
            r_sq   <= r_sq + POS_W'({r_root, 1'b1}) + POS_W'(2);
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.base_init_wr || i_cmd.seg_fill_wr) begin
            r_idx <= r_idx + POS_W'(1);
        end
        if (i_cmd.p_init) begin
            r_p <= RootW'(2);
        end else if (i_cmd.p_inc) begin
            r_p <= r_p + RootW'(1);
        end
        if (i_cmd.m_sq) begin
            r_m <= r_psq;
        end else if (i_cmd.m_load) begin
            r_m <= (r_seg == '0) ? r_psq : next_rdata;
        end else if (i_cmd.base_mark_wr || i_cmd.seg_mark_wr) begin
            r_m <= r_m + POS_W'(r_p);
        end
        if (i_cmd.seg_clr) begin
            r_seg <= '0;
        end else if (i_cmd.seg_adv) begin
            r_seg <= r_seg + SegStep;
        end
        if (i_cmd.seg_top) begin
            r_end <= n_end;
        end
        if (i_cmd.cnt_start) begin
            r_k <= r_seg;
        end else if (i_cmd.cnt_rd) begin
            r_k <= r_k + POS_W'(1);
        end
        if (i_cmd.out_ld) begin
            r_out <= r_total;
        end
    end

    spsc_ram #(
        .WIDTH (1),
        .DEPTH (BaseDepth)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.base_init_wr || i_cmd.base_mark_wr),
        .i_waddr (i_cmd.base_init_wr ? r_idx[BaseAw-1:0] : r_m[BaseAw-1:0]),
        .i_wdata (i_cmd.base_init_wr),
        .i_raddr (r_p[BaseAw-1:0]),
        .o_rdata (base_rdata)
    );

    spsc_ram #(
        .WIDTH (POS_W),
        .DEPTH (BaseDepth)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.next_wr),
        .i_waddr (r_p[BaseAw-1:0]),
        .i_wdata (r_m),
        .i_raddr (r_p[BaseAw-1:0]),
        .o_rdata (next_rdata)
    );

    spsc_ram #(
        .WIDTH (1),
        .DEPTH (SEG_SIZE)
    ) u_seg_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.seg_fill_wr || i_cmd.seg_mark_wr),
        .i_waddr (i_cmd.seg_fill_wr ? r_idx[SegAw-1:0] : m_off[SegAw-1:0]),
        .i_wdata (i_cmd.seg_fill_wr),
        .i_raddr (k_off[SegAw-1:0]),
        .o_rdata (seg_rdata)
    );

    always_comb begin
        o_sts.root_more   = r_sq <= POS_W'(r_n);
        o_sts.idx_at_root = r_idx == POS_W'(r_root);
        o_sts.p_le_root   = r_p <= r_root;
        o_sts.base_flag   = base_rdata;
        o_sts.m_le_root   = r_m <= POS_W'(r_root);
        o_sts.fill_last   = r_idx == SegLast;
        o_sts.m_le_end    = r_m <= r_end;
        o_sts.seg_le_n    = r_seg <= POS_W'(r_n);
        o_sts.k_le_end    = r_k <= r_end;
    end

    assign o_num_primes = r_out;

endmodule

// ===== hdl/spsc_ctrl.sv =====
// ----------------------------------------------------------------------------
// spsc_ctrl
// Sequencer of the sieve: square root search, base sieve, and per segment the
// fill, mark and count passes, then the result hand-off.
// ----------------------------------------------------------------------------
module spsc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    output logic           o_valid,
    input  logic           i_ready,
    input  spsc_pkg::t_sts i_sts,
    output spsc_pkg::t_cmd o_cmd
);
    import spsc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_ROOT, S_BINIT, S_BPRD, S_BPCHK, S_BMARK, S_SEGTOP,
        S_SFILL, S_PRD, S_PCHK, S_PMARK, S_CNT, S_ADV, S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_n = 1'b1;
                    n_state    = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_sts.root_more) begin
                    cmd.root_step = 1'b1;
                end else begin
                    cmd.idx_clr = 1'b1;
                    n_state     = S_BINIT;
                end
            end
            S_BINIT: begin
                cmd.base_init_wr = 1'b1;
                if (i_sts.idx_at_root) begin
                    cmd.p_init = 1'b1;
                    n_state    = S_BPRD;
                end
            end
            S_BPRD: begin
                if (i_sts.p_le_root) begin
                    n_state = S_BPCHK;
                end else begin
                    cmd.seg_clr = 1'b1;
                    n_state     = S_SEGTOP;
                end
            end
            S_BPCHK: begin
                if (i_sts.base_flag) begin
                    cmd.m_sq = 1'b1;
                    n_state  = S_BMARK;
                end else begin
                    cmd.p_inc = 1'b1;
                    n_state   = S_BPRD;
                end
            end
            S_BMARK: begin
                if (i_sts.m_le_root) begin
                    cmd.base_mark_wr = 1'b1;
                end else begin
                    cmd.p_inc = 1'b1;
                    n_state   = S_BPRD;
                end
            end
            S_SEGTOP: begin
                if (i_sts.seg_le_n) begin
                    cmd.seg_top = 1'b1;
                    cmd.idx_clr = 1'b1;
                    n_state     = S_SFILL;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SFILL: begin
                cmd.seg_fill_wr = 1'b1;
                if (i_sts.fill_last) begin
                    cmd.p_init = 1'b1;
                    n_state    = S_PRD;
                end
            end
            S_PRD: begin
                if (i_sts.p_le_root) begin
                    n_state = S_PCHK;
                end else begin
                    cmd.cnt_start = 1'b1;
                    n_state       = S_CNT;
                end
            end
            S_PCHK: begin
                if (i_sts.base_flag) begin
                    cmd.m_load = 1'b1;
                    n_state    = S_PMARK;
                end else begin
                    cmd.p_inc = 1'b1;
                    n_state   = S_PRD;
                end
            end
            S_PMARK: begin
                if (i_sts.m_le_end) begin
                    cmd.seg_mark_wr = 1'b1;
                end else begin
                    cmd.next_wr = 1'b1;
                    cmd.p_inc   = 1'b1;
                    n_state     = S_PRD;
                end
            end
            S_CNT: begin
                if (i_sts.k_le_end) begin
                    cmd.cnt_rd = 1'b1;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ADV: begin
                cmd.seg_adv = 1'b1;
                n_state     = S_SEGTOP;
            end
            S_FIN: begin
                if (!r_out_valid || i_ready) begin
                    cmd.out_ld = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

endmodule

// ===== hdl/segmented_prime_sieve_counter_unit.sv =====
// ----------------------------------------------------------------------------
// segmented_prime_sieve_counter_unit
// Counts the primes up to a limit with a segmented sieve of Eratosthenes.
//
//   Channel  Direction  Beat fields      Handshake
//   input    in         i_limit          i_valid / o_ready
//   output   out        o_num_primes     o_valid / i_ready
//
// A beat runs the root search and the base sieve, then per segment the fill of
// SEG_SIZE flags, a check of each candidate up to sqrt(N), a start load for each
// base prime, a write for each marked multiple and a read for each counted entry.
// Reset is synchronous and needs no clearing pass. A new limit is taken while an
// earlier result still waits in the output register; the next result stalls only then.
// ----------------------------------------------------------------------------
module segmented_prime_sieve_counter_unit #(
    parameter int MAX_N    = spsc_pkg::MAX_N_DEF,
    parameter int SEG_SIZE = spsc_pkg::SEG_SIZE_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [spsc_pkg::LIM_W-1:0] i_limit,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [spsc_pkg::LIM_W-1:0] o_num_primes
);
    import spsc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    spsc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    spsc_datapath #(
        .MAX_N    (MAX_N),
        .SEG_SIZE (SEG_SIZE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_limit      (i_limit),
        .o_sts        (sts),
        .o_num_primes (o_num_primes)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Prime sieve counter testbench
// Sends limits to the segmented prime sieve counter and checks every count
// against a fixed table count or a whole-range sieve built once at time zero.
// A short table covers the smallest limits, square and segment edges, the largest
// limit and a clamped one. Random limits follow, mostly small, with idle cycles on
// both channels, a long output stall and a full drain before the last stretch.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LIM_W         = spsc_pkg::LIM_W;
    localparam int MAX_LIMIT     = spsc_pkg::MAX_N_DEF;
    localparam int SEG           = spsc_pkg::SEG_SIZE_DEF;
    localparam int DIRECTED_ROWS = 21;
    localparam int RANDOM_ITEMS  = 80;
    localparam int TOTAL_ITEMS   = DIRECTED_ROWS + RANDOM_ITEMS;
    localparam int HOLD_CYCLES   = 40000;
    localparam int SHORT_ITEMS   = 10;
    localparam int DRAIN_CYCLES  = 64;
    localparam int CYCLE_LIMIT   = 80_000_000;

    typedef struct {
        logic [LIM_W-1:0] limit;
        bit               known;
        logic [LIM_W-1:0] count;
    } t_probe_row;

    typedef struct {
        logic [LIM_W-1:0] limit;
        logic [LIM_W-1:0] count;
    } t_count_expect;

    logic             i_clk   = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_valid = 1'b0;
    logic [LIM_W-1:0] i_limit = '0;
    logic             i_ready = 1'b0;
    logic             o_ready;
    logic             o_valid;
    logic [LIM_W-1:0] o_num_primes;

    bit               is_composite [0:MAX_LIMIT];
    logic [LIM_W-1:0] prime_tally = '0;
    t_count_expect    pending_counts [$];
    int               mismatches   = 0;
    int               cycles       = 0;
    int               stage        = 0;
    bit               hold_request = 1'b0;

    t_probe_row directed_rows [DIRECTED_ROWS] = '{
        '{21'd0,        1'b1, 21'd0},
        '{21'd1,        1'b1, 21'd0},
        '{21'd2,        1'b1, 21'd1},
        '{21'd3,        1'b1, 21'd2},
        '{21'd4,        1'b0, 21'd0},
        '{21'd24,       1'b0, 21'd0},
        '{21'd25,       1'b0, 21'd0},
        '{21'd26,       1'b0, 21'd0},
        '{21'd120,      1'b0, 21'd0},
        '{21'd121,      1'b0, 21'd0},
        '{21'd1023,     1'b0, 21'd0},
        '{21'd1024,     1'b0, 21'd0},
        '{21'd1025,     1'b0, 21'd0},
        '{21'd4095,     1'b0, 21'd0},
        '{21'd4096,     1'b0, 21'd0},
        '{21'd4097,     1'b0, 21'd0},
        '{21'd8191,     1'b0, 21'd0},
        '{21'd8192,     1'b0, 21'd0},
        '{21'd12288,    1'b0, 21'd0},
        '{21'd1048576,  1'b1, 21'd82025},
        '{21'h1FFFFF,   1'b1, 21'd82025}
    };

    segmented_prime_sieve_counter_unit dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_limit      (i_limit),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_num_primes (o_num_primes)
    );

    initial begin : clock_gen
        forever #4 i_clk = ~i_clk;
    end

    initial begin : reset_seq
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [LIM_W-1:0] count_primes_upto(input logic [LIM_W-1:0] lim);
        int n;
        int k;
        n = (lim > MAX_LIMIT) ? MAX_LIMIT : int'(lim);
        prime_tally = '0;
        for (k = 2; k <= n; k++) begin
            if (!is_composite[k]) begin
                prime_tally = prime_tally + 1'b1;
            end
        end
        return prime_tally;
    endfunction

    function automatic logic [LIM_W-1:0] draw_limit(input bit keep_short);
        int unsigned      pick;
        logic [LIM_W-1:0] lim;
        pick = $urandom_range(99);
        if (keep_short || pick < 65) begin
            lim = LIM_W'($urandom_range(600));
        end else if (pick < 80) begin
            lim = LIM_W'(SEG * $urandom_range(3, 1) + $urandom_range(2) - 1);
        end else begin
            lim = LIM_W'($urandom_range(20000));
        end
        return lim;
    endfunction

    function automatic int idle_pct(input int st, input bit sender_side);
        case (st)
            0:       return sender_side ? 24 : 88;
            1:       return sender_side ? 88 : 24;
            default: return 0;
        endcase
    endfunction

    task automatic offer_limit(input logic [LIM_W-1:0] lim, input logic [LIM_W-1:0] want);
        t_count_expect entry;
        while ($urandom_range(99) < idle_pct(stage, 1'b1)) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_limit <= lim;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        entry.limit = lim;
        entry.count = want;
        pending_counts.push_back(entry);
    endtask

    initial begin : stimulus
        int               p;
        int               m;
        int               idx;
        int               short_left;
        bit               drained;
        logic [LIM_W-1:0] lim;
        logic [LIM_W-1:0] want;
        short_left = 0;
        drained    = 1'b0;
        for (p = 2; p * p <= MAX_LIMIT; p++) begin
            if (!is_composite[p]) begin
                for (m = p * p; m <= MAX_LIMIT; m += p) begin
                    is_composite[m] = 1'b1;
                end
            end
        end
        while (!i_rst_n) @(posedge i_clk);
        for (idx = 0; idx < TOTAL_ITEMS; idx++) begin
            stage = idx * 3 / TOTAL_ITEMS;
            // Before the last stretch the input waits for every count, then the
            // output stalls while short limits keep coming so the block backs up.
            if (stage == 2 && !drained) begin
                drained = 1'b1;
                if (pending_counts.size() != 0) begin
                    i_valid <= 1'b0;
                    while (pending_counts.size() != 0) @(posedge i_clk);
                end
                hold_request = 1'b1;
                short_left   = SHORT_ITEMS;
            end
            if (idx < DIRECTED_ROWS) begin
                lim  = directed_rows[idx].limit;
                want = directed_rows[idx].known ? directed_rows[idx].count
                                                : count_primes_upto(lim);
            end else begin
                lim  = draw_limit(short_left > 0);
                want = count_primes_upto(lim);
                if (short_left > 0) begin
                    short_left--;
                end
            end
            offer_limit(lim, want);
        end
        i_valid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        int            hold_left;
        t_count_expect head;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                if (pending_counts.size() == 0) begin
                    $display("%0t: unexpected count beat: expected none, actual %0d",
                             $time, o_num_primes);
                    mismatches++;
                end else begin
                    head = pending_counts.pop_front();
                    if (o_num_primes !== head.count) begin
                        $display("%0t: count for limit %0d: expected %0d, actual %0d",
                                 $time, head.limit, head.count, o_num_primes);
                        mismatches++;
                    end
                end
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= idle_pct(stage, 1'b0));
            end
        end
    end

endmodule
